/* rtl/pfe_pkg.sv */
`default_nettype none
package pfe_pkg;

  // Key square geometry and field widths
  localparam int SqDim      = 5;
  localparam int LetterW    = 5;
  localparam int RowW       = SqDim * LetterW;
  localparam int PosW       = 3;
  localparam int CfgIdxW    = 3;
  localparam int QueueDepth = 4;

  // Letter codes
  localparam logic [LetterW-1:0] LETTER_X = 5'd23;
  localparam logic [LetterW-1:0] LETTER_J = 5'd9;
  localparam logic [LetterW-1:0] LETTER_I = 5'd8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ROW0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROW3 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ROW4 = 3'd4;

  typedef logic [SqDim-1:0][RowW-1:0] square_t;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [LetterW-1:0] cipher_letter;
    logic               last_of_run;
  } out_item_t;

  // One digraph to encipher; dbl repeats it (doubled letter at end of message)
  typedef struct packed {
    logic [LetterW-1:0] a;
    logic [LetterW-1:0] b;
    logic               dbl;
  } job_t;

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } pos_t;

  // Cell of the square at (r, c)
  function automatic logic [LetterW-1:0] cell_at(square_t sq, logic [PosW-1:0] r,
                                                 logic [PosW-1:0] c);
    logic [RowW-1:0] row_bits;
    row_bits = sq[r];
    return row_bits[int'(c)*LetterW +: LetterW];
  endfunction

  // First matching cell in row-major order, (0,0) when absent
  function automatic pos_t locate(square_t sq, logic [LetterW-1:0] ch);
    pos_t p;
    p = '0;
    for (int r = SqDim - 1; r >= 0; r--) begin
      for (int c = SqDim - 1; c >= 0; c--) begin
        if (sq[r][c*LetterW +: LetterW] == ch) begin
          p.row = PosW'(r);
          p.col = PosW'(c);
        end
      end
    end
    return p;
  endfunction

  // Increment modulo the square size
  function automatic logic [PosW-1:0] wrap_inc(logic [PosW-1:0] v);
    return (v == PosW'(SqDim - 1)) ? '0 : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

/* rtl/playfair_digraph_encrypt_top.sv */
`default_nettype none
// Playfair encryptor over a loadable 5x5 key square. Letters (A=0..Z=25, J
// folded to I) enter one transaction per cycle while the job queue has room;
// the front pairs them into digraphs (X pads doubled letters and an odd final
// letter), and the back locates both letters, applies the row, column or
// rectangle rule and emits two cipher letters per digraph, four when a
// doubled letter ends the message, with last_of_run on the final one. The
// output sequencer sends one letter per cycle unless out_stall holds it; a
// digraph's job passes through the queue, the locate registers and the emit
// registers before out_valid rises for its first letter. Load the five square
// rows through cfg_* only while the block is idle.
module playfair_digraph_encrypt_top #(
  parameter int QUEUE_DEPTH = pfe_pkg::QueueDepth
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire pfe_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output pfe_pkg::out_item_t                out_data,
  input  wire logic                         cfg_we,
  input  wire logic [pfe_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [pfe_pkg::RowW-1:0]     cfg_data
);

  pfe_pkg::square_t square_r;
  logic             q_full, q_nonempty, push, pop;
  pfe_pkg::job_t    push_job, q_head;

  // Key square registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pfe_pkg::REG_ROW0: square_r[0] <= cfg_data;
        pfe_pkg::REG_ROW1: square_r[1] <= cfg_data;
        pfe_pkg::REG_ROW2: square_r[2] <= cfg_data;
        pfe_pkg::REG_ROW3: square_r[3] <= cfg_data;
        pfe_pkg::REG_ROW4: square_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  pfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  pfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  pfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .square     (square_r),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

/* rtl/pfe_front.sv */
`default_nettype none
module pfe_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pfe_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   push,
  output pfe_pkg::job_t          push_job
);

  logic [pfe_pkg::LetterW-1:0] pl_r, pl_nxt;
  logic                        pv_r, pv_nxt;
  logic [pfe_pkg::LetterW-1:0] fl;
  logic                        accept;
  logic                        eom;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign eom      = in_data.end_of_message;

  // J folds to I
  assign fl = (in_data.letter == pfe_pkg::LETTER_J) ? pfe_pkg::LETTER_I : in_data.letter;

  // Pairing: decide the digraph job and the pending letter
  always_comb begin
    pl_nxt   = pl_r;
    pv_nxt   = pv_r;
    push     = 1'b0;
    push_job = '0;
    if (accept) begin
      if (!pv_r) begin
        if (eom) begin
          push     = 1'b1;
          push_job = '{a: fl, b: pfe_pkg::LETTER_X, dbl: 1'b0};
        end else begin
          pl_nxt = fl;
          pv_nxt = 1'b1;
        end
      end else if (pl_r != fl) begin
        push     = 1'b1;
        push_job = '{a: pl_r, b: fl, dbl: 1'b0};
        pv_nxt   = 1'b0;
      end else begin
        // doubled letter: pad with X, second copy opens the next pair
        push     = 1'b1;
        push_job = '{a: pl_r, b: pfe_pkg::LETTER_X, dbl: eom};
      end
      if (eom) begin
        pv_nxt = 1'b0;
        pl_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_r <= '0;
      pv_r <= 1'b0;
    end else begin
      pl_r <= pl_nxt;
      pv_r <= pv_nxt;
    end
  end

  // End of message always closes the open pair
  a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && eom) |=> !pv_r)
    else $error("pending letter survived end of message");

endmodule
`default_nettype wire

/* rtl/pfe_queue.sv */
`default_nettype none
module pfe_queue #(
  parameter int DEPTH = pfe_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pfe_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               nonempty,
  output pfe_pkg::job_t      head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  pfe_pkg::job_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CntW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_r];

  // Pointer and fill count update
  always_comb begin
    wr_nxt  = push ? ((wr_r == PtrW'(DEPTH - 1)) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = pop  ? ((rd_r == PtrW'(DEPTH - 1)) ? '0 : rd_r + 1'b1) : rd_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("queue pop while empty");

endmodule
`default_nettype wire

/* rtl/pfe_back.sv */
`default_nettype none
module pfe_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pfe_pkg::square_t square,
  input  wire logic             q_nonempty,
  input  wire pfe_pkg::job_t    q_head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output pfe_pkg::out_item_t    out_data
);

  // Locate stage
  logic          loc_valid_r;
  pfe_pkg::pos_t pa_r, pb_r;
  logic          loc_dbl_r;

  // Emit stage
  logic                        busy_r;
  logic [1:0]                  cnt_r;
  logic                        dbl_r;
  logic [pfe_pkg::LetterW-1:0] oa_r, ob_r;

  logic                        out_accept, last, emit_load, loc_ready;
  logic [pfe_pkg::LetterW-1:0] oa_nxt, ob_nxt;

  assign out_valid  = busy_r;
  assign out_accept = busy_r && !out_stall;
  assign last       = dbl_r ? (cnt_r == 2'd3) : (cnt_r == 2'd1);
  assign emit_load  = loc_valid_r && (!busy_r || (out_accept && last));
  assign loc_ready  = !loc_valid_r || emit_load;
  assign pop        = q_nonempty && loc_ready;

  assign out_data.cipher_letter = cnt_r[0] ? ob_r : oa_r;
  assign out_data.last_of_run   = last;

  // Cipher rules from the located positions
  always_comb begin
    if (pa_r.row == pb_r.row) begin
      oa_nxt = pfe_pkg::cell_at(square, pa_r.row, pfe_pkg::wrap_inc(pa_r.col));
      ob_nxt = pfe_pkg::cell_at(square, pb_r.row, pfe_pkg::wrap_inc(pb_r.col));
    end else if (pa_r.col == pb_r.col) begin
      oa_nxt = pfe_pkg::cell_at(square, pfe_pkg::wrap_inc(pa_r.row), pa_r.col);
      ob_nxt = pfe_pkg::cell_at(square, pfe_pkg::wrap_inc(pb_r.row), pb_r.col);
    end else begin
      oa_nxt = pfe_pkg::cell_at(square, pa_r.row, pb_r.col);
      ob_nxt = pfe_pkg::cell_at(square, pb_r.row, pa_r.col);
    end
  end

  // Locate stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_valid_r <= 1'b0;
    end else if (loc_ready) begin
      loc_valid_r <= q_nonempty;
    end
  end

  // Locate stage payload: search the square for both letters
  always_ff @(posedge clk) begin
    if (pop) begin
      pa_r      <= pfe_pkg::locate(square, q_head.a);
      pb_r      <= pfe_pkg::locate(square, q_head.b);
      loc_dbl_r <= q_head.dbl;
    end
  end

  // Emit sequencer: two letters per digraph, four when repeated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      dbl_r  <= 1'b0;
    end else if (emit_load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      dbl_r  <= loc_dbl_r;
    end else if (out_accept) begin
      busy_r <= !last;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      oa_r <= oa_nxt;
      ob_r <= ob_nxt;
    end
  end

  a_short_run: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !dbl_r) |-> !cnt_r[1])
    else $error("plain digraph ran past two letters");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_accept && !last) |=> (busy_r && cnt_r == $past(cnt_r) + 2'd1))
    else $error("digraph run cut short");

endmodule
`default_nettype wire

/* dv/pfe_tb_pkg.sv */
`timescale 1ns / 100ps
package pfe_tb_pkg;
  import pfe_pkg::*;

  // Tracks the cipher stream: predicts each transaction's letters and checks the output
  class cipher_scoreboard;
    square_t            key_sq;
    logic [LetterW-1:0] held_letter;
    bit                 held_valid;
    out_item_t          expected_q[$];
    int                 errors;
    int                 letters_seen;
    int                 ciphers_seen;
    int                 n_row;
    int                 n_col;
    int                 n_rect;
    int                 n_doubled;
    int                 n_four;

    function new();
      key_sq       = '0;
      held_letter  = '0;
      held_valid   = 1'b0;
      errors       = 0;
      letters_seen = 0;
      ciphers_seen = 0;
      n_row        = 0;
      n_col        = 0;
      n_rect       = 0;
      n_doubled    = 0;
      n_four       = 0;
    endfunction

    // Register write; indexes past the last row are dropped
    function void load_row(logic [CfgIdxW-1:0] idx, logic [RowW-1:0] val);
      if (idx < SqDim) key_sq[idx] = val;
    endfunction

    function logic [LetterW-1:0] cell_of(int r, int c);
      logic [RowW-1:0] row_bits;
      row_bits = key_sq[r % SqDim];
      return row_bits[(c % SqDim)*LetterW +: LetterW];
    endfunction

    // First hit in row-major order; a missing letter sits at the top-left corner
    function void find_letter(logic [LetterW-1:0] ch, output int r, output int c);
      bit found;
      found = 1'b0;
      r = 0;
      c = 0;
      for (int i = 0; i < SqDim; i++) begin
        for (int j = 0; j < SqDim; j++) begin
          if (!found && cell_of(i, j) == ch) begin
            found = 1'b1;
            r = i;
            c = j;
          end
        end
      end
    endfunction

    function void encipher_pair(logic [LetterW-1:0] a, logic [LetterW-1:0] b);
      int        ra, ca, rb, cb;
      out_item_t oa, ob;
      find_letter(a, ra, ca);
      find_letter(b, rb, cb);
      oa = '0;
      ob = '0;
      if (ra == rb) begin
        // also covers both letters in one cell (padded X X)
        oa.cipher_letter = cell_of(ra, ca + 1);
        ob.cipher_letter = cell_of(rb, cb + 1);
        n_row++;
      end else if (ca == cb) begin
        oa.cipher_letter = cell_of(ra + 1, ca);
        ob.cipher_letter = cell_of(rb + 1, cb);
        n_col++;
      end else begin
        oa.cipher_letter = cell_of(ra, cb);
        ob.cipher_letter = cell_of(rb, ca);
        n_rect++;
      end
      expected_q.push_back(oa);
      expected_q.push_back(ob);
    endfunction

    // Accepted input transaction: pair it up and queue the cipher letters it releases
    function void note_letter(in_item_t it);
      logic [LetterW-1:0] l;
      int                 prev_size;
      l = it.letter;
      if (l == LETTER_J) l = LETTER_I;
      prev_size = expected_q.size();
      letters_seen++;
      if (!held_valid) begin
        if (it.end_of_message) encipher_pair(l, LETTER_X);
        else begin
          held_letter = l;
          held_valid  = 1'b1;
        end
      end else if (held_letter != l) begin
        encipher_pair(held_letter, l);
        held_valid = 1'b0;
      end else begin
        // doubled letter: pad with X, second copy opens the next pair
        n_doubled++;
        encipher_pair(held_letter, LETTER_X);
        if (it.end_of_message) begin
          encipher_pair(l, LETTER_X);
          n_four++;
        end
        held_letter = l;
        held_valid  = 1'b1;
      end
      if (it.end_of_message) begin
        held_valid  = 1'b0;
        held_letter = '0;
      end
      if (expected_q.size() > prev_size) expected_q[expected_q.size()-1].last_of_run = 1'b1;
    endfunction

    // Accepted output transaction against the oldest expectation
    function void check_cipher(out_item_t got);
      out_item_t want;
      ciphers_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected cipher letter %0d (last %0b), nothing expected",
                 $time, got.cipher_letter, got.last_of_run);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.cipher_letter !== want.cipher_letter) begin
        $display("%0t: cipher_letter mismatch, expected %0d, got %0d",
                 $time, want.cipher_letter, got.cipher_letter);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                 $time, want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage

/* dv/tb_playfair_digraph_encrypt_top.sv */
`timescale 1ns / 100ps
module tb_playfair_digraph_encrypt_top;
  import pfe_pkg::*;
  import pfe_tb_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
  localparam int ConfigSettle = 12;
  localparam int QuietLimit   = 4000;
  localparam int LongHold     = 150;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [RowW-1:0] cfg_data;

  cipher_scoreboard sb;
  bit sender_idle_en;
  bit recv_idle_en;
  int hold_seq;
  int quiet_cycles;

  playfair_digraph_encrypt_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (in_valid && !in_stall) sb.note_letter(in_data);
      if (out_valid && !out_stall) sb.check_cipher(out_data);
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
        $display("FAIL playfair_digraph_encrypt_top");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int holds_served;
    holds_served = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != holds_served) begin
        holds_served = hold_seq;
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
        out_stall <= 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one letter; returns right after the edge that took it, valid still high
  task automatic send_letter(in_item_t it);
    @(negedge clk);
    if (sender_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic input_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Let the block go idle before touching the square
  task automatic settle();
    wait_results();
    repeat (ConfigSettle) @(negedge clk);
  endtask

  task automatic write_row(logic [CfgIdxW-1:0] idx, logic [RowW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.load_row(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_square(square_t sq);
    write_row(REG_ROW0, sq[0]);
    write_row(REG_ROW1, sq[1]);
    write_row(REG_ROW2, sq[2]);
    write_row(REG_ROW3, sq[3]);
    write_row(REG_ROW4, sq[4]);
  endtask

  // Proper key square: alphabet without J, optionally shuffled
  function automatic square_t make_square(bit shuffle);
    logic [LetterW-1:0] pool[SqDim*SqDim];
    logic [LetterW-1:0] t;
    logic [RowW-1:0]    row_bits;
    square_t            sq;
    int                 k, j;
    k = 0;
    for (int v = 0; v < 26; v++) begin
      if (LetterW'(v) != LETTER_J) begin
        pool[k] = LetterW'(v);
        k++;
      end
    end
    if (shuffle) begin
      for (int i = SqDim*SqDim - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = pool[i];
        pool[i] = pool[j];
        pool[j] = t;
      end
    end
    for (int r = 0; r < SqDim; r++) begin
      row_bits = '0;
      for (int c = 0; c < SqDim; c++) row_bits[c*LetterW +: LetterW] = pool[r*SqDim + c];
      sq[r] = row_bits;
    end
    return sq;
  endfunction

  // Malformed square: cells drawn from lo..31, so repeats, gaps and codes above Z
  function automatic square_t make_noise_square(int lo);
    logic [RowW-1:0] row_bits;
    square_t         sq;
    for (int r = 0; r < SqDim; r++) begin
      row_bits = '0;
      for (int c = 0; c < SqDim; c++) row_bits[c*LetterW +: LetterW] = LetterW'($urandom_range(lo, 31));
      sq[r] = row_bits;
    end
    return sq;
  endfunction

  // Mostly real text, leaning on doubled letters, J, X and the odd code past Z
  function automatic in_item_t next_letter(logic [LetterW-1:0] prev);
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) it.letter = prev;
    else if (pick < 30) it.letter = LetterW'($urandom_range(26, 31));
    else if (pick < 35) it.letter = LETTER_J;
    else if (pick < 40) it.letter = LETTER_X;
    else it.letter = LetterW'($urandom_range(0, 25));
    it.end_of_message = ($urandom_range(0, 6) == 0);
    return it;
  endfunction

  // Random messages; optional long receiver hold and sender drain mid-stream
  task automatic run_messages(int count, int hold_at, int pause_at, bit close_msg);
    in_item_t           it;
    logic [LetterW-1:0] prev;
    prev = '0;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_seq++;
      if (i == pause_at) begin
        input_quiet();
        wait_results();
      end
      it = next_letter(prev);
      if (close_msg && i == count - 1) it.end_of_message = 1'b1;
      prev = it.letter;
      send_letter(it);
    end
    input_quiet();
  endtask

  // Directed letters against the plain alphabet square
  localparam int NumDirected = 21;
  logic [LetterW-1:0] dir_letter[NumDirected] = '{
    5'd0, 5'd1,                 // same row
    5'd0, 5'd5,                 // same column
    5'd0, 5'd6,                 // rectangle
    5'd4, 5'd25,                // column wrap to the top
    5'd11, 5'd11, 5'd11,        // doubled, then doubled at end of message
    LETTER_J,                   // lone J at end of message
    LETTER_X, LETTER_X, 5'd3,   // doubled pad letter
    5'd31, 5'd26, 5'd25,        // codes missing from the square, odd last letter
    LETTER_J, LETTER_I,         // J folds onto I and doubles
    5'd0
  };
  bit dir_eom[NumDirected] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 1, 0, 0, 1, 0, 1, 1};

  initial begin
    square_t  sq;
    in_item_t it;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ROW0;
    cfg_data = '0;
    sender_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    hold_seq = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Square still at its reset value of all zeros
    run_messages(6, -1, -1, 1'b1);

    settle();
    load_square(make_square(1'b0));
    for (int i = 0; i < NumDirected; i++) begin
      it.letter = dir_letter[i];
      it.end_of_message = dir_eom[i];
      send_letter(it);
    end
    input_quiet();

    settle();
    load_square(make_square(1'b1));
    run_messages(80, -1, -1, 1'b0);

    // Random cells, writes to unused indexes must not land, long receiver hold
    settle();
    load_square(make_noise_square(0));
    write_row(REG_SPARE_LO, RowW'($urandom));
    write_row(REG_SPARE_HI, '1);
    run_messages(80, 20, -1, 1'b0);

    // Register extremes
    settle();
    sq[0] = '1;
    sq[1] = '0;
    sq[2] = '1;
    sq[3] = '0;
    sq[4] = '1;
    load_square(sq);
    run_messages(30, -1, -1, 1'b0);

    // Sender drains the block mid-stream
    settle();
    load_square(make_square(1'b1));
    run_messages(80, -1, 40, 1'b0);

    // Many repeated cells near the top of the code range
    settle();
    load_square(make_noise_square(20));
    run_messages(80, 5, -1, 1'b0);

    // Final stretch at full rate on both sides
    settle();
    sender_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    load_square(make_square(1'b1));
    run_messages(80, -1, -1, 1'b0);

    wait_results();
    repeat (ConfigSettle) @(posedge clk);
    $display("Run: %0d letters in, %0d cipher letters out over proper, noisy and reset squares",
             sb.letters_seen, sb.ciphers_seen);
    $display("Digraphs: %0d row, %0d column, %0d rectangle; %0d doubled, %0d four-letter ends",
             sb.n_row, sb.n_col, sb.n_rect, sb.n_doubled, sb.n_four);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS playfair_digraph_encrypt_top");
    end else begin
      $display("FAIL playfair_digraph_encrypt_top");
    end
    $finish;
  end

endmodule
